// ----- rtl/mlrq_pkg.sv -----
// Shared types, codes and a helper function of the multilevel ready queue.
package mlrq_pkg;

  localparam int LEVEL_COUNT = 3;
  localparam logic [1:0] LEVEL_LAST = 2'd2;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_EXTRACTED = 3'd1,
    STAT_NONE      = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_ZERO_PID  = 3'd4
  } status_t;

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  localparam logic CFG_LEVEL0_LIMIT = 1'b0;
  localparam logic CFG_LEVEL1_LIMIT = 1'b1;

  localparam logic [7:0] LEVEL0_LIMIT_RST = 8'd100;
  localparam logic [7:0] LEVEL1_LIMIT_RST = 8'd130;

  localparam logic [2:0] AFF_ANY = 3'b111;

  typedef struct packed {
    logic        vld;
    logic [15:0] pid;
    logic [7:0]  prio;
    logic [2:0]  aff;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Any-CPU tasks match every request; other negative affinities match none.
  function automatic logic may_run(logic [2:0] aff, logic [1:0] cpu);
    return (aff == AFF_ANY) || (!aff[2] && (aff[1:0] == cpu));
  endfunction

endpackage

// ----- rtl/multilevel_ready_queue_affinity_select.sv -----
// Top level of the three-level ready queue: limit registers, slot memory and sequencer.
// After reset the block clears its slot memory with busy high.
// An operation is accepted when start is high and busy is low; its one result appears on
// out_status for a single cycle with out_valid, and busy is low in that same cycle. The slot
// memory has one read port and the sequencer examines one slot per cycle, so an insert
// answers once it finds the first free slot of its level or has read the whole level, an
// extract once a level holding a runnable task or the last level has been read to its end,
// and a zero pid insert or an extract from a CPU outside the CPU count answers in the cycle
// after acceptance. The receiver cannot stall results. Limit registers may be written at
// any time busy is low and no operation is pending.
module multilevel_ready_queue_affinity_select
  import mlrq_pkg::*;
#(
  parameter int SLOTS_PER_LEVEL = 64,
  parameter int CPU_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_func,
  input  logic [15:0]       in_task_pid,
  input  logic [7:0]        in_task_priority,
  input  logic signed [2:0] in_task_affinity,
  input  logic [1:0]        in_cpu_id,
  output logic              out_valid,
  output logic [2:0]        out_status,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata
);

  localparam int TOTAL = LEVEL_COUNT * SLOTS_PER_LEVEL;
  localparam int AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;

  logic [7:0]    level0_limit_r;
  logic [7:0]    level1_limit_r;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level0_limit_r <= LEVEL0_LIMIT_RST;
      level1_limit_r <= LEVEL1_LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LEVEL0_LIMIT) begin
        level0_limit_r <= cfg_wdata;
      end else begin
        level1_limit_r <= cfg_wdata;
      end
    end
  end

  mlrq_ctrl #(
    .SLOTS_PER_LEVEL(SLOTS_PER_LEVEL),
    .CPU_COUNT      (CPU_COUNT)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_task_pid     (in_task_pid),
    .in_task_priority(in_task_priority),
    .in_task_affinity($unsigned(in_task_affinity)),
    .in_cpu_id       (in_cpu_id),
    .level0_limit    (level0_limit_r),
    .level1_limit    (level1_limit_r),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  mlrq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TOTAL)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

// ----- rtl/mlrq_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module mlrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mlrq_ctrl.sv -----
// Sequencer that clears, scans and updates the slot memory for insert and extract.
module mlrq_ctrl
  import mlrq_pkg::*;
#(
  parameter int SLOTS_PER_LEVEL = 64,
  parameter int CPU_COUNT = 4,
  localparam int TOTAL = LEVEL_COUNT * SLOTS_PER_LEVEL,
  localparam int AW = (TOTAL > 1) ? $clog2(TOTAL) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic          in_func,
  input  logic [15:0]   in_task_pid,
  input  logic [7:0]    in_task_priority,
  input  logic [2:0]    in_task_affinity,
  input  logic [1:0]    in_cpu_id,
  input  logic [7:0]    level0_limit,
  input  logic [7:0]    level1_limit,
  output logic          out_valid,
  output logic [2:0]    out_status,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output entry_t        ram_wdata,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  input  entry_t        ram_rdata
);

  localparam int IW = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_INS, S_EXT} state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] raddr_r, raddr_nxt;
  logic [AW-1:0] end_r, end_nxt;
  logic [IW-1:0] iidx_r, iidx_nxt;
  logic          iss_r, iss_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic          rd_last_r, rd_last_nxt;
  logic [1:0]    lvl_r, lvl_nxt;
  logic [15:0]   pid_r, pid_nxt;
  logic [7:0]    prio_r, prio_nxt;
  logic [2:0]    aff_r, aff_nxt;
  logic [1:0]    cpu_r, cpu_nxt;
  logic          best_found_r, best_found_nxt;
  logic [7:0]    best_prio_r, best_prio_nxt;
  logic [AW-1:0] best_addr_r, best_addr_nxt;
  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;

  logic          accept;
  logic          issue;
  logic          hit;
  logic          last_of_level;
  logic [AW-1:0] ins_base;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign issue      = iss_r && ((state_r == S_INS) || (state_r == S_EXT));
  assign ram_re     = issue;
  assign ram_raddr  = raddr_r;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  assign last_of_level = (iidx_r == IW'(SLOTS_PER_LEVEL - 1));

  assign hit = rd_pend_r && ram_rdata.vld && may_run(ram_rdata.aff, cpu_r) &&
               (!best_found_r || (ram_rdata.prio < best_prio_r));

  always_comb begin
    if (in_task_priority < level0_limit) begin
      ins_base = '0;
    end else if (in_task_priority < level1_limit) begin
      ins_base = AW'(SLOTS_PER_LEVEL);
    end else begin
      ins_base = AW'(2 * SLOTS_PER_LEVEL);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    raddr_nxt      = raddr_r;
    end_nxt        = end_r;
    iidx_nxt       = iidx_r;
    iss_nxt        = iss_r;
    rd_pend_nxt    = issue;
    rd_addr_nxt    = raddr_r;
    rd_last_nxt    = last_of_level;
    lvl_nxt        = lvl_r;
    pid_nxt        = pid_r;
    prio_nxt       = prio_r;
    aff_nxt        = aff_r;
    cpu_nxt        = cpu_r;
    best_found_nxt = best_found_r;
    best_prio_nxt  = best_prio_r;
    best_addr_nxt  = best_addr_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = rd_addr_r;
    ram_wdata      = '0;

    // Reads go out one slot per cycle; data comes back in the following cycle.
    if (issue) begin
      raddr_nxt = raddr_r + AW'(1);
      iidx_nxt  = last_of_level ? '0 : iidx_r + IW'(1);
      if (raddr_r == end_r) begin
        iss_nxt = 1'b0;
      end
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = raddr_r;
        raddr_nxt = raddr_r + AW'(1);
        if (raddr_r == AW'(TOTAL - 1)) begin
          raddr_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          pid_nxt        = in_task_pid;
          prio_nxt       = in_task_priority;
          aff_nxt        = in_task_affinity;
          cpu_nxt        = in_cpu_id;
          iidx_nxt       = '0;
          lvl_nxt        = '0;
          best_found_nxt = 1'b0;
          if (in_func == FUNC_INSERT) begin
            if (in_task_pid == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_ZERO_PID;
            end else begin
              raddr_nxt = ins_base;
              end_nxt   = ins_base + AW'(SLOTS_PER_LEVEL - 1);
              iss_nxt   = 1'b1;
              state_nxt = S_INS;
            end
          end else if ({1'b0, in_cpu_id} >= 3'(CPU_COUNT)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_NONE;
          end else begin
            raddr_nxt = '0;
            end_nxt   = AW'(TOTAL - 1);
            iss_nxt   = 1'b1;
            state_nxt = S_EXT;
          end
        end
      end
      S_INS: begin
        if (rd_pend_r) begin
          if (!ram_rdata.vld) begin
            ram_we         = 1'b1;
            ram_waddr      = rd_addr_r;
            ram_wdata      = '{vld: 1'b1, pid: pid_r, prio: prio_r, aff: aff_r};
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_INSERTED;
            iss_nxt        = 1'b0;
            state_nxt      = S_IDLE;
          end else if (rd_last_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_FULL;
            iss_nxt        = 1'b0;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_EXT: begin
        if (hit) begin
          best_found_nxt = 1'b1;
          best_prio_nxt  = ram_rdata.prio;
          best_addr_nxt  = rd_addr_r;
        end
        if (rd_pend_r && rd_last_r) begin
          if (hit || best_found_r) begin
            // Free the winning slot; its payload is dead once valid drops.
            ram_we         = 1'b1;
            ram_waddr      = hit ? rd_addr_r : best_addr_r;
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_EXTRACTED;
            iss_nxt        = 1'b0;
            state_nxt      = S_IDLE;
          end else if (lvl_r == LEVEL_LAST) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_NONE;
            iss_nxt        = 1'b0;
            state_nxt      = S_IDLE;
          end else begin
            lvl_nxt        = lvl_r + 2'd1;
            best_found_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      raddr_r      <= '0;
      iss_r        <= 1'b0;
      rd_pend_r    <= 1'b0;
      best_found_r <= 1'b0;
      lvl_r        <= '0;
      iidx_r       <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= STAT_NONE;
    end else begin
      state_r      <= state_nxt;
      raddr_r      <= raddr_nxt;
      iss_r        <= iss_nxt;
      rd_pend_r    <= rd_pend_nxt;
      best_found_r <= best_found_nxt;
      lvl_r        <= lvl_nxt;
      iidx_r       <= iidx_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
    end
    end_r       <= end_nxt;
    rd_addr_r   <= rd_addr_nxt;
    rd_last_r   <= rd_last_nxt;
    pid_r       <= pid_nxt;
    prio_r      <= prio_nxt;
    aff_r       <= aff_nxt;
    cpu_r       <= cpu_nxt;
    best_prio_r <= best_prio_nxt;
    best_addr_r <= best_addr_nxt;
  end

  // The scan never reads the entry that is being written in the same cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("slot read and write collide");

  // A result always returns the block to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result shown while busy");

  // An insert only ever writes an occupied entry.
  a_insert_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS && ram_we) |-> ram_wdata.vld)
    else $error("insert wrote an empty entry");

  // Freeing a slot during an extract is always reported as an extract.
  a_extract_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXT && ram_we) |=> (out_valid_r && out_status_r == STAT_EXTRACTED))
    else $error("freed slot without extract status");

endmodule

// ----- tb/sv/mlrq_checker.sv -----
// Checker for the ready queue: tracks slot contents, predicts each status and compares it.
module mlrq_checker
  import mlrq_pkg::*;
#(
  parameter int SLOTS_PER_LEVEL = 64,
  parameter int CPU_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic              in_func,
  input  logic [15:0]       in_task_pid,
  input  logic [7:0]        in_task_priority,
  input  logic signed [2:0] in_task_affinity,
  input  logic [1:0]        in_cpu_id,
  input  logic              out_valid,
  input  logic [2:0]        out_status,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata,
  output int                fail_count,
  output int                pending,
  output int                n_extracted,
  output int                n_full,
  output int                n_none
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_SLOTS = LEVEL_COUNT * SLOTS_PER_LEVEL;
  localparam int NO_CANDIDATE = 1000;

  logic [7:0]  level0_lim;
  logic [7:0]  level1_lim;
  logic        slot_used [TOTAL_SLOTS];
  logic [15:0] slot_task [TOTAL_SLOTS];
  logic [7:0]  slot_prio [TOTAL_SLOTS];
  logic [2:0]  slot_aff  [TOTAL_SLOTS];

  status_t expected_status_q [$];

  function automatic int level_for(logic [7:0] prio);
    if (prio < level0_lim) return 0;
    if (prio < level1_lim) return 1;
    return 2;
  endfunction

  function automatic status_t insert_task(logic [15:0] pid, logic [7:0] prio, logic [2:0] aff);
    int base;
    if (pid == 16'd0) return STAT_ZERO_PID;
    base = level_for(prio) * SLOTS_PER_LEVEL;
    for (int i = 0; i < SLOTS_PER_LEVEL; i++) begin
      if (!slot_used[base + i]) begin
        slot_used[base + i] = 1'b1;
        slot_task[base + i] = pid;
        slot_prio[base + i] = prio;
        slot_aff[base + i]  = aff;
        return STAT_INSERTED;
      end
    end
    return STAT_FULL;
  endfunction

  // Affinity codes 4 to 6 are negative values other than any, and match no CPU.
  function automatic logic cpu_allowed(logic [2:0] aff, logic [1:0] cpu);
    return (aff == AFF_ANY) || (aff < 3'd4 && aff == {1'b0, cpu});
  endfunction

  function automatic status_t extract_task(logic [1:0] cpu);
    int best_slot;
    int best_prio;
    int s;
    if (int'(cpu) >= CPU_COUNT) return STAT_NONE;
    for (int lvl = 0; lvl < LEVEL_COUNT; lvl++) begin
      best_slot = -1;
      best_prio = NO_CANDIDATE;
      for (int i = 0; i < SLOTS_PER_LEVEL; i++) begin
        s = lvl * SLOTS_PER_LEVEL + i;
        if (slot_used[s] && cpu_allowed(slot_aff[s], cpu) && int'(slot_prio[s]) < best_prio) begin
          best_prio = int'(slot_prio[s]);
          best_slot = s;
        end
      end
      if (best_slot >= 0) begin
        slot_used[best_slot] = 1'b0;
        return STAT_EXTRACTED;
      end
    end
    return STAT_NONE;
  endfunction

  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      level0_lim = LEVEL0_LIMIT_RST;
      level1_lim = LEVEL1_LIMIT_RST;
      for (int i = 0; i < TOTAL_SLOTS; i++) slot_used[i] = 1'b0;
      expected_status_q.delete();
      fail_count  <= 0;
      pending     <= 0;
      n_extracted <= 0;
      n_full      <= 0;
      n_none      <= 0;
    end else begin
      // The result of an earlier transaction is retired before a new one is predicted.
      if (out_valid === 1'b1) begin
        if (expected_status_q.size() == 0) begin
          $error("out_status: no transaction outstanding, actual %0d", out_status);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_status_q.pop_front();
          if (out_status !== want) begin
            $error("out_status mismatch: expected %0d, actual %0d", want, out_status);
            fail_count <= fail_count + 1;
          end
          if (want == STAT_EXTRACTED) n_extracted <= n_extracted + 1;
          if (want == STAT_FULL) n_full <= n_full + 1;
          if (want == STAT_NONE) n_none <= n_none + 1;
        end
      end
      if (cfg_we === 1'b1) begin
        if (cfg_index == CFG_LEVEL0_LIMIT) level0_lim = cfg_wdata;
        else level1_lim = cfg_wdata;
      end
      if (start === 1'b1 && busy === 1'b0) begin
        if (in_func == FUNC_INSERT)
          want = insert_task(in_task_pid, in_task_priority, in_task_affinity);
        else
          want = extract_task(in_cpu_id);
        expected_status_q.push_back(want);
      end
      pending <= expected_status_q.size();
    end
  end

endmodule

// ----- tb/sv/multilevel_ready_queue_affinity_select_tb.sv -----
// Top of the ready queue testbench: clock, reset, stimulus phases and the final verdict.
module multilevel_ready_queue_affinity_select_tb
  import mlrq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;
  localparam int CPUS = 4;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int END_DRAIN = 3 * SLOTS + 8;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_func = FUNC_INSERT;
  logic [15:0]       in_task_pid = '0;
  logic [7:0]        in_task_priority = '0;
  logic signed [2:0] in_task_affinity = '0;
  logic [1:0]        in_cpu_id = '0;
  logic              out_valid;
  logic [2:0]        out_status;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_LEVEL0_LIMIT;
  logic [7:0]        cfg_wdata = '0;

  int fail_count;
  int pending;
  int n_extracted;
  int n_full;
  int n_none;
  int n_sent = 0;
  int n_settings = 0;
  int cycle_count = 0;
  bit gapless = 1'b0;

  multilevel_ready_queue_affinity_select #(
    .SLOTS_PER_LEVEL(SLOTS),
    .CPU_COUNT(CPUS)
  ) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_task_pid(in_task_pid), .in_task_priority(in_task_priority),
    .in_task_affinity(in_task_affinity), .in_cpu_id(in_cpu_id),
    .out_valid(out_valid), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  mlrq_checker #(
    .SLOTS_PER_LEVEL(SLOTS),
    .CPU_COUNT(CPUS)
  ) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_task_pid(in_task_pid), .in_task_priority(in_task_priority),
    .in_task_affinity(in_task_affinity), .in_cpu_id(in_cpu_id),
    .out_valid(out_valid), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending),
    .n_extracted(n_extracted), .n_full(n_full), .n_none(n_none)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multilevel_ready_queue_affinity_select verification failed");
      $finish;
    end
  end

  // Returns just after the edge at which the transaction was accepted; start stays high.
  task automatic send_op(logic func, logic [15:0] pid, logic [7:0] prio,
                         logic signed [2:0] aff, logic [1:0] cpu);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_func <= func;
    in_task_pid <= pid;
    in_task_priority <= prio;
    in_task_affinity <= aff;
    in_cpu_id <= cpu;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    n_sent++;
  endtask

  task automatic settle_queue();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy !== 1'b0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limits(logic [7:0] lim0, logic [7:0] lim1);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LEVEL0_LIMIT;
    cfg_wdata <= lim0;
    @(posedge clk);
    cfg_index <= CFG_LEVEL1_LIMIT;
    cfg_wdata <= lim1;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic random_op(int insert_pct);
    logic [15:0] pid;
    logic [7:0] prio;
    logic signed [2:0] aff;
    int r;
    pid = ($urandom_range(0, 99) < 3) ? 16'd0 : 16'($urandom_range(1, 65535));
    prio = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 139)) : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    // Tasks pinned to no CPU never leave, so they are kept rare.
    if (r < 40) aff = -3'sd1;
    else if (r < 95) aff = 3'($urandom_range(0, 3));
    else aff = 3'($urandom_range(4, 6));
    send_op(($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_EXTRACT,
            pid, prio, aff, 2'($urandom_range(0, 3)));
  endtask

  // Settles the queue, writes the limits, then sends random bursts with an insert share of 85, 25 or 55 percent.
  task automatic run_phase(logic [7:0] lim0, logic [7:0] lim1, int count);
    int done;
    int burst;
    int pct;
    int r;
    settle_queue();
    write_limits(lim0, lim1);
    done = 0;
    while (done < count) begin
      burst = $urandom_range(20, 90);
      r = $urandom_range(0, 2);
      pct = (r == 0) ? 85 : (r == 1) ? 25 : 55;
      gapless = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < burst && done < count; j++) begin
        random_op(pct);
        done++;
      end
    end
    gapless = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset limits of 100 and 130.
    send_op(FUNC_EXTRACT, 16'd0, 8'd0, -3'sd1, 2'd0);
    send_op(FUNC_INSERT, 16'd0, 8'd10, -3'sd1, 2'd0);
    send_op(FUNC_INSERT, 16'hFFFF, 8'd0, -3'sd1, 2'd3);
    send_op(FUNC_INSERT, 16'd1, 8'd139, 3'sd3, 2'd0);
    send_op(FUNC_INSERT, 16'd2, 8'd99, 3'sd0, 2'd0);
    send_op(FUNC_INSERT, 16'd3, 8'd100, 3'sd1, 2'd0);
    send_op(FUNC_INSERT, 16'd4, 8'd129, 3'sd2, 2'd0);
    send_op(FUNC_INSERT, 16'd5, 8'd130, -3'sd1, 2'd0);
    send_op(FUNC_INSERT, 16'd6, 8'd255, 3'sd0, 2'd0);
    send_op(FUNC_INSERT, 16'd7, 8'd0, -3'sd2, 2'd0);
    send_op(FUNC_INSERT, 16'd8, 8'd0, -3'sd3, 2'd0);
    send_op(FUNC_INSERT, 16'd9, 8'd0, -3'sd4, 2'd0);
    send_op(FUNC_INSERT, 16'd10, 8'd50, 3'sd3, 2'd0);
    send_op(FUNC_INSERT, 16'd11, 8'd50, 3'sd3, 2'd0);
    send_op(FUNC_EXTRACT, 16'hFFFF, 8'hFF, 3'sd0, 2'd3);
    send_op(FUNC_EXTRACT, 16'd0, 8'd0, 3'sd0, 2'd3);
    send_op(FUNC_EXTRACT, 16'd0, 8'd0, 3'sd0, 2'd1);
    send_op(FUNC_EXTRACT, 16'd0, 8'd0, 3'sd0, 2'd2);
    send_op(FUNC_EXTRACT, 16'd0, 8'd0, 3'sd0, 2'd0);
    send_op(FUNC_EXTRACT, 16'd0, 8'd0, 3'sd0, 2'd3);
    send_op(FUNC_EXTRACT, 16'd0, 8'd0, 3'sd0, 2'd3);
    send_op(FUNC_EXTRACT, 16'd0, 8'd0, 3'sd0, 2'd0);
    send_op(FUNC_EXTRACT, 16'd0, 8'd0, 3'sd0, 2'd2);

    run_phase(LEVEL0_LIMIT_RST, LEVEL1_LIMIT_RST, 250);
    run_phase(8'd0, 8'd0, 260);
    run_phase(8'd255, 8'd255, 260);
    // Limits out of order leave level one unused.
    run_phase(8'd140, 8'd60, 250);
    run_phase(8'($urandom_range(0, 140)), 8'($urandom_range(0, 140)), 260);
    run_phase(8'd50, 8'd140, 250);

    settle_queue();
    repeat (END_DRAIN) @(posedge clk);

    $display("Sent %0d transactions under %0d limit settings in %0d cycles.",
             n_sent, n_settings, cycle_count);
    $display("Outcomes: %0d extracted, %0d refused on a full level, %0d with nothing runnable.",
             n_extracted, n_full, n_none);
    if (pending != 0) $error("out_status: %0d transactions never answered", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("multilevel_ready_queue_affinity_select verification clean");
    end else begin
      $display("multilevel_ready_queue_affinity_select verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mlrq_pkg.sv
rtl/mlrq_ram.sv
rtl/mlrq_ctrl.sv
rtl/multilevel_ready_queue_affinity_select.sv
tb/sv/mlrq_checker.sv
tb/sv/multilevel_ready_queue_affinity_select_tb.sv
